[rtl/bsab_pkg.sv]
// Shared types, constants and arithmetic helpers of the bilinear scale and alpha blend block.
package bsab_pkg;

    // Size limits of the two images.
    localparam int MAX_SMALL_WIDTH  = 256;
    localparam int MAX_SMALL_HEIGHT = 256;
    localparam int MAX_LARGE_DIM    = 4096;

    localparam int STORE_DEPTH = MAX_SMALL_WIDTH * MAX_SMALL_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int XI_W        = $clog2(MAX_SMALL_WIDTH);
    localparam int YI_W        = $clog2(MAX_SMALL_HEIGHT);
    localparam int POS_W       = $clog2(MAX_LARGE_DIM);

    // Pixel layout: blue in the low byte, then green, then red.
    localparam int CH_W     = 8;
    localparam int CHANNELS = 3;
    localparam int PIX_W    = CH_W * CHANNELS;

    // Register widths.
    localparam int RATIO_W   = 9;
    localparam int LDIM_W    = 13;
    localparam int SDIM_W    = 9;
    localparam int STEP_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 17;

    localparam int RATIO_ONE = 256;
    localparam int STEP_ONE  = 65536;
    localparam int FRAC_W    = 16;
    localparam int WGT_W     = 8;
    localparam int SX_W      = POS_W + STEP_W;

    // Result queue.
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEND_RATIO  = 3'd0,
        CFG_LARGE_WIDTH  = 3'd1,
        CFG_LARGE_HEIGHT = 3'd2,
        CFG_SMALL_WIDTH  = 3'd3,
        CFG_SMALL_HEIGHT = 3'd4,
        CFG_X_STEP       = 3'd5,
        CFG_Y_STEP       = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_BLEND = 1'b1
    } t_op;

    // Configuration after saturation and the zero-means-one rule.
    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [LDIM_W-1:0]  lw;
        logic [LDIM_W-1:0]  lh;
        logic [SDIM_W-1:0]  sw;
        logic [SDIM_W-1:0]  sh;
        logic [STEP_W-1:0]  xs;
        logic [STEP_W-1:0]  ys;
    } t_cfg;

    // Blend request in the second read cycle, handed to the interpolator.
    typedef struct packed {
        logic             valid;
        logic [WGT_W-1:0] fx;
        logic [WGT_W-1:0] fy;
        logic [PIX_W-1:0] px;
        logic             last;
    } t_pix;

    // Store port controls driven by the address front end.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [PIX_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_mem_ctl;

    // (a * (256 - w) + b * w) >> 8, w in Q1.8 with 256 meaning 1.0.
    function automatic logic [CH_W-1:0] mix8(input logic [CH_W-1:0] a,
                                             input logic [CH_W-1:0] b,
                                             input logic [RATIO_W-1:0] w);
        logic [2*CH_W:0] s;
        s = (2*CH_W+1)'(a) * (2*CH_W+1)'(RATIO_W'(RATIO_ONE) - w)
          + (2*CH_W+1)'(b) * (2*CH_W+1)'(w);
        return s[2*CH_W-1:CH_W];
    endfunction

endpackage

[rtl/bsab_ram.sv]
// Generic RAM with one write port and two registered read ports.
module bsab_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[rtl/bsab_front.sv]
// Request intake, position counters and neighbor address pipeline.
module bsab_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsab_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  logic              i_op,
    input  logic [23:0]       i_px,
    input  logic              i_credit_ok,
    output logic              o_ready,
    output logic              o_blend_take,
    output bsab_pkg::t_mem_ctl o_mem,
    output bsab_pkg::t_pix    o_pix
);
    import bsab_pkg::*;

    logic              accept;
    logic              r_hold;
    logic [ADDR_W-1:0] r_load_count, n_load_count;
    logic [POS_W-1:0]  r_col, n_col, r_row, n_row;
    logic [ADDR_W:0]   limit, lc_inc;
    logic [ADDR_W-1:0] lc_cur;
    logic              row_end, frame_end;

    // Stage A: accepted request with its position.
    logic              r_a_valid, r_a_op, r_a_last;
    logic [PIX_W-1:0]  r_a_px;
    logic [POS_W-1:0]  r_a_col, r_a_row;
    logic [ADDR_W-1:0] r_a_waddr;
    // Stage B: scaled positions.
    logic              r_b_valid, r_b_op, r_b_last;
    logic [PIX_W-1:0]  r_b_px;
    logic [SX_W-1:0]   r_b_sx, r_b_sy;
    logic [ADDR_W-1:0] r_b_waddr;
    // Stage C: row bases and clamped columns, first read pair.
    logic              r_c_valid, r_c_op, r_c_last;
    logic [PIX_W-1:0]  r_c_px;
    logic [ADDR_W-1:0] r_c_waddr, r_c_base0, r_c_base1;
    logic [XI_W-1:0]   r_c_x0, r_c_x1;
    logic [WGT_W-1:0]  r_c_fx, r_c_fy;
    // Stage D: second read pair.
    logic              r_d_valid, r_d_last;
    logic [PIX_W-1:0]  r_d_px;
    logic [ADDR_W-1:0] r_d_base1;
    logic [XI_W-1:0]   r_d_x0, r_d_x1;
    logic [WGT_W-1:0]  r_d_fx, r_d_fy;

    logic [POS_W-1:0]  xi, yi;
    logic [POS_W:0]    xi1, yi1;
    logic [SDIM_W-1:0] swm1, shm1;
    logic [XI_W-1:0]   x0, x1;
    logic [YI_W-1:0]   y0, y1;
    logic [ADDR_W:0]   base0, base1;

    // A blend request blocks intake in the cycle after it, which leaves the store's
    // read ports free for its second read pair and keeps loads in order.
    assign o_ready      = !r_hold && i_credit_ok;
    assign accept       = i_valid && o_ready;
    assign o_blend_take = accept && (i_op == OP_BLEND);

    always_comb begin
        limit        = (ADDR_W+1)'(i_cfg.sw) * (ADDR_W+1)'(i_cfg.sh);
        lc_cur       = ({1'b0, r_load_count} >= limit) ? '0 : r_load_count;
        lc_inc       = (ADDR_W+1)'(lc_cur) + 1'b1;
        n_load_count = (lc_inc >= limit) ? '0 : lc_inc[ADDR_W-1:0];
        row_end      = (LDIM_W'(r_col) + 1'b1) >= i_cfg.lw;
        frame_end    = row_end && ((LDIM_W'(r_row) + 1'b1) >= i_cfg.lh);
        n_col        = row_end ? '0 : r_col + 1'b1;
        n_row        = frame_end ? '0 : (row_end ? r_row + 1'b1 : r_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold       <= 1'b0;
            r_load_count <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_c_valid    <= 1'b0;
            r_d_valid    <= 1'b0;
        end else begin
            r_hold    <= o_blend_take;
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid && (r_c_op == OP_BLEND);
            if (accept && (i_op == OP_LOAD)) begin
                r_load_count <= n_load_count;
            end
            if (o_blend_take) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_comb begin
        xi   = r_b_sx[FRAC_W +: POS_W];
        yi   = r_b_sy[FRAC_W +: POS_W];
        xi1  = {1'b0, xi} + 1'b1;
        yi1  = {1'b0, yi} + 1'b1;
        swm1 = i_cfg.sw - 1'b1;
        shm1 = i_cfg.sh - 1'b1;
        x0   = (xi >= POS_W'(swm1)) ? swm1[XI_W-1:0] : xi[XI_W-1:0];
        x1   = (xi1 >= (POS_W+1)'(swm1)) ? swm1[XI_W-1:0] : xi1[XI_W-1:0];
        y0   = (yi >= POS_W'(shm1)) ? shm1[YI_W-1:0] : yi[YI_W-1:0];
        y1   = (yi1 >= (POS_W+1)'(shm1)) ? shm1[YI_W-1:0] : yi1[YI_W-1:0];
        base0 = (ADDR_W+1)'(y0) * (ADDR_W+1)'(i_cfg.sw);
        base1 = (ADDR_W+1)'(y1) * (ADDR_W+1)'(i_cfg.sw);
    end

    always_ff @(posedge i_clk) begin
        r_a_op    <= i_op;
        r_a_px    <= i_px;
        r_a_col   <= r_col;
        r_a_row   <= r_row;
        r_a_last  <= frame_end;
        r_a_waddr <= lc_cur;

        r_b_op    <= r_a_op;
        r_b_px    <= r_a_px;
        r_b_last  <= r_a_last;
        r_b_waddr <= r_a_waddr;
        r_b_sx    <= SX_W'(r_a_col) * SX_W'(i_cfg.xs);
        r_b_sy    <= SX_W'(r_a_row) * SX_W'(i_cfg.ys);

        r_c_op    <= r_b_op;
        r_c_px    <= r_b_px;
        r_c_last  <= r_b_last;
        r_c_waddr <= r_b_waddr;
        r_c_base0 <= base0[ADDR_W-1:0];
        r_c_base1 <= base1[ADDR_W-1:0];
        r_c_x0    <= x0;
        r_c_x1    <= x1;
        r_c_fx    <= r_b_sx[FRAC_W-1 -: WGT_W];
        r_c_fy    <= r_b_sy[FRAC_W-1 -: WGT_W];

        r_d_px    <= r_c_px;
        r_d_last  <= r_c_last;
        r_d_base1 <= r_c_base1;
        r_d_x0    <= r_c_x0;
        r_d_x1    <= r_c_x1;
        r_d_fx    <= r_c_fx;
        r_d_fy    <= r_c_fy;
    end

    always_comb begin
        o_mem.we    = r_c_valid && (r_c_op == OP_LOAD);
        o_mem.waddr = r_c_waddr;
        o_mem.wdata = r_c_px;
        if (r_d_valid) begin
            o_mem.raddr_a = r_d_base1 + ADDR_W'(r_d_x0);
            o_mem.raddr_b = r_d_base1 + ADDR_W'(r_d_x1);
        end else begin
            o_mem.raddr_a = r_c_base0 + ADDR_W'(r_c_x0);
            o_mem.raddr_b = r_c_base0 + ADDR_W'(r_c_x1);
        end
        o_pix.valid = r_d_valid;
        o_pix.fx    = r_d_fx;
        o_pix.fy    = r_d_fy;
        o_pix.px    = r_d_px;
        o_pix.last  = r_d_last;
    end

endmodule

[rtl/bsab_interp.sv]
// Bilinear interpolation of the four neighbors and the alpha blend.
module bsab_interp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bsab_pkg::t_pix         i_pix,
    input  logic [23:0]            i_rdata_a,
    input  logic [23:0]            i_rdata_b,
    input  logic [8:0]             i_ratio,
    output logic                   o_valid,
    output logic [23:0]            o_pixel,
    output logic                   o_last
);
    import bsab_pkg::*;

    logic             r_e_valid, r_e_last;
    logic [WGT_W-1:0] r_e_fx, r_e_fy;
    logic [PIX_W-1:0] r_e_px, r_e_p00, r_e_p01;

    logic             r_f_valid, r_f_last;
    logic [WGT_W-1:0] r_f_fx;
    logic [PIX_W-1:0] r_f_px, r_f_left, r_f_right;

    logic             r_g_valid, r_g_last;
    logic [PIX_W-1:0] r_g_px, r_g_h;

    logic [PIX_W-1:0] left, right, h, blended;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
        end else begin
            r_e_valid <= i_pix.valid;
            r_f_valid <= r_e_valid;
            r_g_valid <= r_f_valid;
        end
    end

    // The top pair arrives in the cycle before the bottom pair.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            left[c*CH_W +: CH_W]  = mix8(r_e_p00[c*CH_W +: CH_W],
                                         i_rdata_a[c*CH_W +: CH_W], {1'b0, r_e_fy});
            right[c*CH_W +: CH_W] = mix8(r_e_p01[c*CH_W +: CH_W],
                                         i_rdata_b[c*CH_W +: CH_W], {1'b0, r_e_fy});
            h[c*CH_W +: CH_W]     = mix8(r_f_left[c*CH_W +: CH_W],
                                         r_f_right[c*CH_W +: CH_W], {1'b0, r_f_fx});
            blended[c*CH_W +: CH_W] = mix8(r_g_h[c*CH_W +: CH_W],
                                           r_g_px[c*CH_W +: CH_W], i_ratio);
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_fx    <= i_pix.fx;
        r_e_fy    <= i_pix.fy;
        r_e_px    <= i_pix.px;
        r_e_last  <= i_pix.last;
        r_e_p00   <= i_rdata_a;
        r_e_p01   <= i_rdata_b;

        r_f_fx    <= r_e_fx;
        r_f_px    <= r_e_px;
        r_f_last  <= r_e_last;
        r_f_left  <= left;
        r_f_right <= right;

        r_g_px    <= r_f_px;
        r_g_last  <= r_f_last;
        r_g_h     <= h;
    end

    assign o_valid = r_g_valid;
    assign o_pixel = blended;
    assign o_last  = r_g_last;

endmodule

[rtl/bsab_outq.sv]
// Result queue with credit tracking for blend requests in flight.
module bsab_outq (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic        i_push,
    input  logic [23:0] i_pixel,
    input  logic        i_last,
    output logic        o_credit_ok,
    output logic        o_valid,
    output logic [23:0] o_pixel,
    output logic        o_last,
    input  logic        i_ready
);
    import bsab_pkg::*;

    logic [PIX_W:0]      r_q [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [OQ_CNT_W-1:0] r_fill, r_owed;
    logic                pop;

    assign o_valid     = (r_fill != '0);
    assign pop         = o_valid && i_ready;
    assign o_pixel     = r_q[r_rd_ptr][PIX_W-1:0];
    assign o_last      = r_q[r_rd_ptr][PIX_W];
    // Every blend in flight owns a queue slot, so the queue never overflows.
    assign o_credit_ok = (r_owed < OQ_CNT_W'(OQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_owed   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fill <= r_fill + OQ_CNT_W'(i_push) - OQ_CNT_W'(pop);
            r_owed <= r_owed + OQ_CNT_W'(i_take) - OQ_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= {i_last, i_pixel};
        end
    end

endmodule

[rtl/bilinear_scale_alpha_blend.sv]
// Top level of the bilinear scale and alpha blend block.
//
// The block first takes the pixels of a small BGR image (tuser low) in raster
// order into a 64K-entry pixel store, one request per cycle while intake is not
// held. It then takes the pixels of a large image (tuser high), maps each position
// into the small image by the Q1.16 steps, bilinearly interpolates the four
// neighbors (clamped at the last row and column), blends the result with the large
// pixel by blend_ratio and returns one pixel, with tlast on the last pixel of the
// large image. A blend request reads its four neighbors as two pairs through the
// store's two read ports, the top pair and then the bottom pair. The block blocks
// intake for the cycle after each blend request, which also keeps every store
// write and read in request order. An eight-entry result queue lets intake go on
// while results wait, and intake stops only when eight results are owed. The store
// has no reset and no clearing pass: a pixel must be loaded before it is read.
// The user must write configuration through the plain write port only while the
// block is idle; the block itself does not enforce this.
module bilinear_scale_alpha_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    // Incoming pixel requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // in_blue, in_green, in_red
    input  logic        s_axis_tuser,   // op
    // Blended pixels
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_blue, out_green, out_red
    output logic        m_axis_tlast    // frame_end
);
    import bsab_pkg::*;

    logic [RATIO_W-1:0] r_blend_ratio;
    logic [LDIM_W-1:0]  r_large_width, r_large_height;
    logic [SDIM_W-1:0]  r_small_width, r_small_height;
    logic [STEP_W-1:0]  r_x_step, r_y_step;

    t_cfg       cfg;
    t_mem_ctl   mem;
    t_pix       pix;
    logic       credit_ok, blend_take;
    logic [PIX_W-1:0] rdata_a, rdata_b, blend_pixel;
    logic       blend_valid, blend_last;

    // Registers are kept as written; saturation and the rule that zero counts
    // as one are applied on the way out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_ratio  <= RATIO_W'(128);
            r_large_width  <= LDIM_W'(1);
            r_large_height <= LDIM_W'(1);
            r_small_width  <= SDIM_W'(1);
            r_small_height <= SDIM_W'(1);
            r_x_step       <= STEP_W'(STEP_ONE);
            r_y_step       <= STEP_W'(STEP_ONE);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BLEND_RATIO:  r_blend_ratio  <= i_cfg_data[RATIO_W-1:0];
                CFG_LARGE_WIDTH:  r_large_width  <= i_cfg_data[LDIM_W-1:0];
                CFG_LARGE_HEIGHT: r_large_height <= i_cfg_data[LDIM_W-1:0];
                CFG_SMALL_WIDTH:  r_small_width  <= i_cfg_data[SDIM_W-1:0];
                CFG_SMALL_HEIGHT: r_small_height <= i_cfg_data[SDIM_W-1:0];
                CFG_X_STEP:       r_x_step       <= i_cfg_data[STEP_W-1:0];
                CFG_Y_STEP:       r_y_step       <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.ratio = (r_blend_ratio > RATIO_W'(RATIO_ONE)) ? RATIO_W'(RATIO_ONE)
                                                          : r_blend_ratio;
        cfg.lw = (r_large_width == '0) ? LDIM_W'(1) :
                 (r_large_width > LDIM_W'(MAX_LARGE_DIM)) ? LDIM_W'(MAX_LARGE_DIM)
                                                          : r_large_width;
        cfg.lh = (r_large_height == '0) ? LDIM_W'(1) :
                 (r_large_height > LDIM_W'(MAX_LARGE_DIM)) ? LDIM_W'(MAX_LARGE_DIM)
                                                           : r_large_height;
        cfg.sw = (r_small_width == '0) ? SDIM_W'(1) :
                 (r_small_width > SDIM_W'(MAX_SMALL_WIDTH)) ? SDIM_W'(MAX_SMALL_WIDTH)
                                                            : r_small_width;
        cfg.sh = (r_small_height == '0) ? SDIM_W'(1) :
                 (r_small_height > SDIM_W'(MAX_SMALL_HEIGHT)) ? SDIM_W'(MAX_SMALL_HEIGHT)
                                                              : r_small_height;
        cfg.xs = (r_x_step > STEP_W'(STEP_ONE)) ? STEP_W'(STEP_ONE) : r_x_step;
        cfg.ys = (r_y_step > STEP_W'(STEP_ONE)) ? STEP_W'(STEP_ONE) : r_y_step;
    end

    // Intake, position counters and neighbor addressing.
    bsab_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (s_axis_tvalid),
        .i_op         (s_axis_tuser),
        .i_px         (s_axis_tdata),
        .i_credit_ok  (credit_ok),
        .o_ready      (s_axis_tready),
        .o_blend_take (blend_take),
        .o_mem        (mem),
        .o_pix        (pix)
    );

    // Small image store: loads write it, blends read two neighbors per cycle.
    bsab_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (mem.we),
        .i_waddr   (mem.waddr),
        .i_wdata   (mem.wdata),
        .i_raddr_a (mem.raddr_a),
        .i_raddr_b (mem.raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Vertical mix, horizontal mix and blend, one multiply stage each.
    bsab_interp u_interp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (pix),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .i_ratio   (cfg.ratio),
        .o_valid   (blend_valid),
        .o_pixel   (blend_pixel),
        .o_last    (blend_last)
    );

    // Results wait here for the downstream side.
    bsab_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (blend_take),
        .i_push      (blend_valid),
        .i_pixel     (blend_pixel),
        .i_last      (blend_last),
        .o_credit_ok (credit_ok),
        .o_valid     (m_axis_tvalid),
        .o_pixel     (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .i_ready     (m_axis_tready)
    );

endmodule

[tb/testbench.sv]
// Self-checking testbench for the bilinear scale and alpha blend block.
module testbench;
    import bsab_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_TAIL  = 16;
    localparam int MAX_GAP     = 20;

    // One blended pixel as it should leave the block.
    typedef struct packed {
        logic [2:0][CH_W-1:0] bgr;      // [0] blue, [1] green, [2] red
        logic                 frame_end;
    } t_blended;

    // Store addresses of the four neighbors and the Q0.8 weights of one large pixel.
    typedef struct packed {
        logic [ADDR_W-1:0] a00;
        logic [ADDR_W-1:0] a01;
        logic [ADDR_W-1:0] a10;
        logic [ADDR_W-1:0] a11;
        logic [WGT_W-1:0]  fx;
        logic [WGT_W-1:0]  fy;
    } t_taps;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_index   = CFG_BLEND_RATIO;
    logic [16:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // in_blue, in_green, in_red
    logic        s_axis_tuser  = OP_LOAD; // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // out_blue, out_green, out_red
    logic        m_axis_tlast;          // frame_end

    // Predictor state: register copies, the small image and the stream position.
    logic [RATIO_W-1:0] r_ratio = 9'd128;
    logic [LDIM_W-1:0]  r_lw    = 13'd1;
    logic [LDIM_W-1:0]  r_lh    = 13'd1;
    logic [SDIM_W-1:0]  r_sw    = 9'd1;
    logic [SDIM_W-1:0]  r_sh    = 9'd1;
    logic [STEP_W-1:0]  r_xs    = 17'd65536;
    logic [STEP_W-1:0]  r_ys    = 17'd65536;
    logic [PIX_W-1:0]   small_pix     [0:STORE_DEPTH-1];
    bit                 small_written [0:STORE_DEPTH-1];
    int unsigned        load_addr = 0;
    int unsigned        cur_col   = 0;
    int unsigned        cur_row   = 0;

    t_blended blended_due[$];
    int       mismatches     = 0;
    int       items_sent     = 0;
    int       cycle_count    = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;

    bilinear_scale_alpha_blend i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Sizes as the block uses them: zero counts as one, larger values saturate.
    function automatic int unsigned clip_dim(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [CH_W-1:0] weigh(input logic [CH_W-1:0] a,
                                             input logic [CH_W-1:0] b,
                                             input logic [WGT_W-1:0] w);
        int unsigned s;
        s = a * (256 - w) + b * w;
        return CH_W'(s >> 8);
    endfunction

    function automatic t_taps taps_at();
        int unsigned sw, sh, sx, sy, xi, yi, x0, x1, y0, y1;
        t_taps t;
        sw = clip_dim(r_sw, MAX_SMALL_WIDTH);
        sh = clip_dim(r_sh, MAX_SMALL_HEIGHT);
        sx = cur_col * ((r_xs > STEP_ONE) ? STEP_ONE : r_xs);
        sy = cur_row * ((r_ys > STEP_ONE) ? STEP_ONE : r_ys);
        xi = sx >> FRAC_W;
        yi = sy >> FRAC_W;
        t.fx = WGT_W'(sx >> 8);
        t.fy = WGT_W'(sy >> 8);
        // Neighbors past the last column or row fall back onto it.
        x0 = (xi >= sw - 1) ? sw - 1 : xi;
        x1 = (xi + 1 >= sw - 1) ? sw - 1 : xi + 1;
        y0 = (yi >= sh - 1) ? sh - 1 : yi;
        y1 = (yi + 1 >= sh - 1) ? sh - 1 : yi + 1;
        t.a00 = ADDR_W'(y0 * sw + x0);
        t.a01 = ADDR_W'(y0 * sw + x1);
        t.a10 = ADDR_W'(y1 * sw + x0);
        t.a11 = ADDR_W'(y1 * sw + x1);
        return t;
    endfunction

    function automatic void store_pixel(input logic [PIX_W-1:0] pix);
        int unsigned limit;
        limit = clip_dim(r_sw, MAX_SMALL_WIDTH) * clip_dim(r_sh, MAX_SMALL_HEIGHT);
        // A load pointer left beyond a shrunken image starts over at once.
        if (load_addr >= limit) load_addr = 0;
        small_pix[load_addr]     = pix;
        small_written[load_addr] = 1'b1;
        load_addr++;
        if (load_addr >= limit) load_addr = 0;
    endfunction

    function automatic void predict_blend(input logic [PIX_W-1:0] pix);
        t_taps           t;
        t_blended        e;
        int unsigned     ratio, lw, lh;
        logic [CH_W-1:0] left, right, interp;
        bit              row_end;
        t     = taps_at();
        ratio = (r_ratio > RATIO_ONE) ? RATIO_ONE : r_ratio;
        lw    = clip_dim(r_lw, MAX_LARGE_DIM);
        lh    = clip_dim(r_lh, MAX_LARGE_DIM);
        // Vertical mix of each column first, then across, then the blend.
        for (int c = 0; c < CHANNELS; c++) begin
            left   = weigh(small_pix[t.a00][8*c +: 8], small_pix[t.a10][8*c +: 8], t.fy);
            right  = weigh(small_pix[t.a01][8*c +: 8], small_pix[t.a11][8*c +: 8], t.fy);
            interp = weigh(left, right, t.fx);
            e.bgr[c] = CH_W'((pix[8*c +: 8] * ratio + interp * (RATIO_ONE - ratio)) >> 8);
        end
        row_end     = (cur_col + 1 >= lw);
        e.frame_end = row_end && (cur_row + 1 >= lh);
        blended_due.push_back(e);
        if (row_end) begin
            cur_col = 0;
            cur_row = e.frame_end ? 0 : cur_row + 1;
        end else begin
            cur_col++;
        end
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Sometimes sets random bits above the register field, which the block must drop.
    function automatic logic [16:0] with_junk(input int unsigned value, input int width);
        logic [16:0] v;
        v = 17'(value);
        if ($urandom_range(1)) v = v | (17'($urandom) << width);
        return v;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [16:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BLEND_RATIO:  r_ratio = value[RATIO_W-1:0];
            CFG_LARGE_WIDTH:  r_lw    = value[LDIM_W-1:0];
            CFG_LARGE_HEIGHT: r_lh    = value[LDIM_W-1:0];
            CFG_SMALL_WIDTH:  r_sw    = value[SDIM_W-1:0];
            CFG_SMALL_HEIGHT: r_sh    = value[SDIM_W-1:0];
            CFG_X_STEP:       r_xs    = value[STEP_W-1:0];
            CFG_Y_STEP:       r_ys    = value[STEP_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Presents one request, with a random idle gap first, and predicts it once taken.
    task automatic send_pixel(input t_op op, input logic [PIX_W-1:0] pix);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= pix;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op == OP_LOAD) begin
            store_pixel(pix);
        end else begin
            predict_blend(pix);
        end
        items_sent++;
    endtask

    // Holds requests back until every owed pixel is out, then waits tail cycles more.
    task automatic settle(input int tail);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (blended_due.size() != 0);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    endtask

    always @(posedge i_clk) begin : check_results
        t_blended want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (blended_due.size() == 0) begin
                report_mismatch("pixel with none owed", 1, 0);
            end else begin
                want = blended_due.pop_front();
                for (int c = 0; c < CHANNELS; c++) begin
                    if (m_axis_tdata[8*c +: 8] !== want.bgr[c]) begin
                        report_mismatch((c == 0) ? "blue" : (c == 1) ? "green" : "red",
                                        m_axis_tdata[8*c +: 8], want.bgr[c]);
                    end
                end
                if (m_axis_tlast !== want.frame_end) begin
                    report_mismatch("frame_end", m_axis_tlast, want.frame_end);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Registers at their reset values: 1x1 images, half blend, every pixel ends a frame.
    task automatic test_reset_values();
        send_pixel(OP_LOAD, 24'hFFFFFF);
        send_pixel(OP_BLEND, 24'h000000);
        send_pixel(OP_BLEND, 24'hFFFFFF);
        send_pixel(OP_LOAD, 24'h000000);
        send_pixel(OP_BLEND, 24'hA55A0F);
    endtask

    // A 2x2 image stretched over a 3x2 frame, shown without the large image.
    task automatic test_scaling();
        settle(DRAIN_TAIL);
        write_reg(CFG_BLEND_RATIO, 17'h1FE00);  // ratio field zero under set high bits
        write_reg(CFG_LARGE_WIDTH, 17'd3);
        write_reg(CFG_LARGE_HEIGHT, 17'd2);
        write_reg(CFG_SMALL_WIDTH, 17'd2);
        write_reg(CFG_SMALL_HEIGHT, 17'd2);
        write_reg(CFG_X_STEP, 17'd43690);
        write_reg(CFG_Y_STEP, 17'd32768);
        send_pixel(OP_LOAD, 24'h0000FF);
        send_pixel(OP_LOAD, 24'h00FF00);
        send_pixel(OP_LOAD, 24'hFF0000);
        send_pixel(OP_LOAD, 24'hFFFFFF);
        repeat (6) send_pixel(OP_BLEND, 24'h000000);
    endtask

    // Values above each register's range saturate, and zero sizes act as one.
    task automatic test_register_extremes();
        settle(DRAIN_TAIL);
        write_reg(CFG_BLEND_RATIO, 17'h1FFFF);
        write_reg(CFG_LARGE_WIDTH, 17'd8191);
        write_reg(CFG_LARGE_HEIGHT, 17'd8191);
        write_reg(CFG_SMALL_WIDTH, 17'd511);
        write_reg(CFG_SMALL_HEIGHT, 17'd0);
        write_reg(CFG_X_STEP, 17'h1FFFF);
        write_reg(CFG_Y_STEP, 17'd0);
        repeat (3) send_pixel(OP_BLEND, pick_pixel());
        // A column already past a narrowed row ends that row on the next pixel.
        settle(DRAIN_TAIL);
        write_reg(CFG_BLEND_RATIO, 17'd1);
        write_reg(CFG_LARGE_WIDTH, 17'd1);
        write_reg(CFG_X_STEP, 17'd0);
        repeat (2) send_pixel(OP_BLEND, 24'hFFFFFF);
    endtask

    // Shrinking the image below the load pointer sends the next load to entry zero.
    task automatic test_load_wrap();
        settle(DRAIN_TAIL);
        write_reg(CFG_SMALL_WIDTH, 17'd2);
        write_reg(CFG_SMALL_HEIGHT, 17'd2);
        repeat (3) send_pixel(OP_LOAD, pick_pixel());
        settle(DRAIN_TAIL);
        write_reg(CFG_SMALL_HEIGHT, 17'd1);
        send_pixel(OP_LOAD, 24'h123456);
        send_pixel(OP_BLEND, 24'hEDCBA9);
    endtask

    // Phases of random geometry: load the small image, then stream large frames.
    task automatic test_random_frames();
        int          phase;
        int unsigned sw, sh, lw, lh, raw_sw, raw_lw, raw_lh, step, loads, blends, pause_at;
        t_taps       t;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle(DRAIN_TAIL);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase

            // Mostly tiny images, with a full-width row and a full-height column now and then.
            case (phase % 6)
                2:       begin sw = MAX_SMALL_WIDTH; sh = 1; end
                5:       begin sw = 1; sh = MAX_SMALL_HEIGHT; end
                default: begin sw = $urandom_range(1, 8); sh = $urandom_range(1, 8); end
            endcase
            raw_sw = (sw == MAX_SMALL_WIDTH) ? $urandom_range(256, 511) :
                     (sw == 1 && $urandom_range(3) == 0) ? 0 : sw;
            lw = $urandom_range(1, 16);
            lh = $urandom_range(1, 8);
            raw_lw = lw;
            raw_lh = lh;
            if ($urandom_range(11) == 0) begin
                raw_lw = 0;
                lw     = 1;
            end else if ($urandom_range(11) == 0) begin
                raw_lw = $urandom_range(4096, 8191);
                lw     = MAX_LARGE_DIM;
            end
            if ($urandom_range(11) == 0) begin
                raw_lh = 0;
                lh     = 1;
            end

            case ($urandom_range(9))
                0, 1:    write_reg(CFG_BLEND_RATIO, with_junk($urandom_range(1) ? 256 : 0,
                                                               RATIO_W));
                2:       write_reg(CFG_BLEND_RATIO, with_junk($urandom_range(257, 511),
                                                               RATIO_W));
                default: write_reg(CFG_BLEND_RATIO, with_junk($urandom_range(0, 256),
                                                               RATIO_W));
            endcase
            write_reg(CFG_LARGE_WIDTH, with_junk(raw_lw, LDIM_W));
            write_reg(CFG_LARGE_HEIGHT, with_junk(raw_lh, LDIM_W));
            write_reg(CFG_SMALL_WIDTH, with_junk(raw_sw, SDIM_W));
            write_reg(CFG_SMALL_HEIGHT, with_junk(sh, SDIM_W));
            // Steps are usually the true size ratio, sometimes anything the field holds.
            step = (sw * STEP_ONE) / lw;
            if (step > 17'h1FFFF || $urandom_range(3) == 0) step = $urandom_range(0, 17'h1FFFF);
            write_reg(CFG_X_STEP, 17'(step));
            step = (sh * STEP_ONE) / lh;
            if (step > 17'h1FFFF || $urandom_range(3) == 0) step = $urandom_range(0, 17'h1FFFF);
            write_reg(CFG_Y_STEP, 17'(step));

            // A whole image fills every entry whatever the pointer; some phases break off.
            loads = sw * sh;
            if ($urandom_range(9) == 0) loads = $urandom_range(0, loads - 1);
            repeat (loads) send_pixel(OP_LOAD, pick_pixel());

            blends   = $urandom_range(60, 150);
            pause_at = $urandom_range(0, blends - 1);
            for (int i = 0; i < blends; i++) begin
                if (i == pause_at) settle(0);
                t = taps_at();
                // Stray loads are noise; a pixel whose neighbors were never loaded
                // becomes a load instead.
                if ($urandom_range(99) < 6 || !(small_written[t.a00] && small_written[t.a01]
                        && small_written[t.a10] && small_written[t.a11])) begin
                    send_pixel(OP_LOAD, pick_pixel());
                end else begin
                    send_pixel(OP_BLEND, pick_pixel());
                end
            end
            phase++;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_scaling();
        test_register_extremes();
        test_load_wrap();
        test_random_frames();
        settle(DRAIN_TAIL);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
